### design/ccioc_pkg.sv
package ccioc_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] CMD_LOAD_COINAGE = 3'd1;
    localparam logic [2:0] CMD_CREDIT_MODE  = 3'd2;
    localparam logic [2:0] CMD_REMAP_OFF    = 3'd3;
    localparam logic [2:0] CMD_REMAP_ON     = 3'd4;
    localparam logic [2:0] CMD_SWITCH_MODE  = 3'd5;

    localparam logic [1:0] OPM_SWITCH  = 2'd0;
    localparam logic [1:0] OPM_CREDIT  = 2'd1;
    localparam logic [1:0] OPM_STARTED = 2'd2;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    localparam logic [2:0] LOAD_STEPS = 3'd4;

    localparam int SW_START1 = 2;
    localparam int SW_START2 = 3;
    localparam int SW_COIN1  = 4;
    localparam int SW_COIN2  = 5;
    localparam int SW_SERV   = 6;
    localparam int SW_TEST   = 7;

    localparam logic [7:0] DIP_B_RESET    = 8'd107;
    localparam logic [7:0] TEST_READ_BYTE = 8'hbb;
    localparam logic [6:0] CREDIT_CEILING = 7'd99;
    localparam logic [6:0] FREE_PLAY_CRED = 7'd100;
    localparam logic [3:0] TALLY_MAX      = 4'd15;

    function automatic logic [3:0] joy_remap(input logic [3:0] v);
        logic [3:0] r;
        unique case (v)
            4'h0: r = 4'hf;
            4'h1: r = 4'he;
            4'h2: r = 4'hd;
            4'h3: r = 4'h5;
            4'h4: r = 4'hc;
            4'h5: r = 4'h9;
            4'h6: r = 4'h7;
            4'h7: r = 4'h6;
            4'h8: r = 4'hb;
            4'h9: r = 4'h3;
            4'ha: r = 4'ha;
            4'hb: r = 4'h4;
            4'hc: r = 4'h1;
            4'hd: r = 4'h2;
            4'he: r = 4'h0;
            4'hf: r = 4'h8;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    // tens digit by reciprocal multiply, exact for all 7-bit values
    function automatic logic [7:0] credit_bcd(input logic [6:0] v);
        logic [17:0] p;
        logic [3:0]  q;
        logic [6:0]  r;
        p = 18'(v) * 18'd205;
        q = p[14:11];
        r = 7'(v - 7'({3'b000, q} * 7'd10));
        return {q, r[3:0]};
    endfunction

endpackage

### design/coin_credit_io_controller_unit.sv
// Output: the result of a request is registered and presented in the cycle after it is accepted.
// Throughput: one request per cycle; a new request is taken whenever the
// result register is empty or is being drained in the same cycle.
// Reset: synchronous, active low; clears all chip state and the result valid flag,
// and loads DIP bank B with 0x6B. A chip-reset request clears all but DIP bank B.
module coin_credit_io_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,   // dip_bank_b
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [2:0] write_data, [10:3] switches, [15:11] zero
    input  logic [1:0]  s_axis_tuser,    // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata     // [7:0] read_data
);

    logic [7:0] r_dip_b;
    logic [1:0] r_op_mode,   n_op_mode;
    logic [1:0] r_phase,     n_phase;
    logic [6:0] r_credits,   n_credits;
    logic [3:0] r_tally     [0:1];
    logic [3:0] n_tally     [0:1];
    logic [2:0] r_cpc       [0:1];
    logic [2:0] n_cpc       [0:1];
    logic [2:0] r_cred      [0:1];
    logic [2:0] n_cred      [0:1];
    logic [2:0] r_load_step, n_load_step;
    logic       r_remap,     n_remap;
    logic [7:0] r_last_sw,   n_last_sw;
    logic [1:0] r_last_btn,  n_last_btn;
    logic       r_out_valid;
    logic [7:0] r_out_data,  n_out_data;

    logic       accept;
    logic [1:0] in_mode;
    logic [2:0] in_wdata;
    logic [7:0] in_sw;

    assign in_mode  = s_axis_tuser;
    assign in_wdata = s_axis_tdata[2:0];
    assign in_sw    = s_axis_tdata[10:3];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        logic [7:0] act;
        logic [7:0] rise;
        logic [3:0] t;
        logic [1:0] bmask;
        logic [3:0] joy;
        logic       edge_hit;
        logic       lvl;
        act      = ~in_sw;
        rise     = act & ~r_last_sw;
        t        = 4'd0;
        bmask    = 2'b00;
        joy      = 4'd0;
        edge_hit = 1'b0;
        lvl      = 1'b0;

        n_op_mode   = r_op_mode;
        n_phase     = r_phase;
        n_credits   = r_credits;
        n_tally     = r_tally;
        n_cpc       = r_cpc;
        n_cred      = r_cred;
        n_load_step = r_load_step;
        n_remap     = r_remap;
        n_last_sw   = r_last_sw;
        n_last_btn  = r_last_btn;
        n_out_data  = 8'd0;

        if (in_mode == ccioc_pkg::MODE_WRITE) begin
            if (r_load_step != 3'd0) begin
                priority case (r_load_step)
                    3'd4:    n_cpc[0]  = in_wdata;
                    3'd3:    n_cred[0] = in_wdata;
                    3'd2:    n_cpc[1]  = in_wdata;
                    default: n_cred[1] = in_wdata;
                endcase
                n_load_step = r_load_step - 3'd1;
            end else begin
                unique case (in_wdata)
                    ccioc_pkg::CMD_LOAD_COINAGE: begin
                        n_load_step = ccioc_pkg::LOAD_STEPS;
                        n_credits   = 7'd0;
                    end
                    ccioc_pkg::CMD_CREDIT_MODE: begin
                        n_op_mode = ccioc_pkg::OPM_CREDIT;
                        n_phase   = ccioc_pkg::PHASE_FIRST;
                    end
                    ccioc_pkg::CMD_REMAP_OFF: n_remap = 1'b0;
                    ccioc_pkg::CMD_REMAP_ON:  n_remap = 1'b1;
                    ccioc_pkg::CMD_SWITCH_MODE: begin
                        n_op_mode = ccioc_pkg::OPM_SWITCH;
                        n_phase   = ccioc_pkg::PHASE_FIRST;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (in_mode == ccioc_pkg::MODE_READ) begin
            n_phase = (r_phase >= ccioc_pkg::PHASE_THIRD) ? ccioc_pkg::PHASE_FIRST
                                                          : r_phase + 2'd1;
            if (r_op_mode == ccioc_pkg::OPM_SWITCH) begin
                priority if (r_phase == ccioc_pkg::PHASE_FIRST) begin
                    n_out_data = in_sw;
                end else if (r_phase == ccioc_pkg::PHASE_SECOND) begin
                    n_out_data = r_dip_b;
                end else begin
                    n_out_data = 8'd0;
                end
            end else if (r_phase == ccioc_pkg::PHASE_FIRST) begin
                n_last_sw = act;
                if (r_cpc[0] != 3'd0) begin
                    if (r_credits < ccioc_pkg::CREDIT_CEILING) begin
                        for (int s = 0; s < 2; s++) begin
                            if (rise[ccioc_pkg::SW_COIN1 + s]) begin
                                t = (r_tally[s] < ccioc_pkg::TALLY_MAX) ? r_tally[s] + 4'd1
                                                                       : r_tally[s];
                                if (t >= {1'b0, r_cpc[s]}) begin
                                    n_credits = 7'(n_credits + {4'b0000, r_cred[s]});
                                    t         = t - {1'b0, r_cpc[s]};
                                end
                                n_tally[s] = t;
                            end
                        end
                        if (rise[ccioc_pkg::SW_SERV]) begin
                            n_credits = n_credits + 7'd1;
                        end
                    end
                end else begin
                    n_credits = ccioc_pkg::FREE_PLAY_CRED;
                end
                if (r_op_mode == ccioc_pkg::OPM_CREDIT) begin
                    priority if (rise[ccioc_pkg::SW_START1]) begin
                        if (n_credits >= 7'd1) begin
                            n_credits = n_credits - 7'd1;
                            n_op_mode = ccioc_pkg::OPM_STARTED;
                        end
                    end else if (rise[ccioc_pkg::SW_START2]) begin
                        if (n_credits >= 7'd2) begin
                            n_credits = n_credits - 7'd2;
                            n_op_mode = ccioc_pkg::OPM_STARTED;
                        end
                    end
                end
                n_out_data = act[ccioc_pkg::SW_TEST] ? ccioc_pkg::TEST_READ_BYTE
                                                     : ccioc_pkg::credit_bcd(n_credits);
            end else begin
                bmask      = (r_phase == ccioc_pkg::PHASE_SECOND) ? 2'b01 : 2'b10;
                joy        = (r_phase == ccioc_pkg::PHASE_SECOND) ? r_dip_b[3:0]
                                                                  : r_dip_b[7:4];
                lvl        = |(act[1:0] & bmask);
                edge_hit   = |(act[1:0] & ~r_last_btn & bmask);
                n_last_btn = (r_last_btn & ~bmask) | (act[1:0] & bmask);
                if (r_remap) begin
                    joy = ccioc_pkg::joy_remap(joy);
                end
                n_out_data = {2'b00, !lvl, !edge_hit, joy};
            end
        end else if (in_mode == ccioc_pkg::MODE_CLEAR) begin
            n_op_mode   = ccioc_pkg::OPM_SWITCH;
            n_phase     = ccioc_pkg::PHASE_FIRST;
            n_credits   = 7'd0;
            n_tally[0]  = 4'd0;
            n_tally[1]  = 4'd0;
            n_cpc[0]    = 3'd0;
            n_cpc[1]    = 3'd0;
            n_cred[0]   = 3'd0;
            n_cred[1]   = 3'd0;
            n_load_step = 3'd0;
            n_remap     = 1'b0;
            n_last_sw   = 8'd0;
            n_last_btn  = 2'b00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_b     <= ccioc_pkg::DIP_B_RESET;
            r_op_mode   <= ccioc_pkg::OPM_SWITCH;
            r_phase     <= ccioc_pkg::PHASE_FIRST;
            r_credits   <= 7'd0;
            r_tally[0]  <= 4'd0;
            r_tally[1]  <= 4'd0;
            r_cpc[0]    <= 3'd0;
            r_cpc[1]    <= 3'd0;
            r_cred[0]   <= 3'd0;
            r_cred[1]   <= 3'd0;
            r_load_step <= 3'd0;
            r_remap     <= 1'b0;
            r_last_sw   <= 8'd0;
            r_last_btn  <= 2'b00;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dip_b <= i_cfg_wr_data;
            end
            if (accept) begin
                r_op_mode   <= n_op_mode;
                r_phase     <= n_phase;
                r_credits   <= n_credits;
                r_tally     <= n_tally;
                r_cpc       <= n_cpc;
                r_cred      <= n_cred;
                r_load_step <= n_load_step;
                r_remap     <= n_remap;
                r_last_sw   <= n_last_sw;
                r_last_btn  <= n_last_btn;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credits <= 7'd113)
        else $error("credit count beyond reachable range");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3 && r_op_mode != 2'd3)
        else $error("read phase or operating mode out of range");

    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_step <= ccioc_pkg::LOAD_STEPS)
        else $error("coinage load step out of range");

    a_chip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_mode == ccioc_pkg::MODE_CLEAR) |=>
        (r_credits == 7'd0 && r_op_mode == ccioc_pkg::OPM_SWITCH && r_load_step == 3'd0))
        else $error("chip reset request did not clear state");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending result lost while stalled");

endmodule

### bench/coin_credit_io_checker.sv
`timescale 1ns / 1ps

module coin_credit_io_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] i_req_data,     // [2:0] write_data, [10:3] switches, [15:11] zero
    input  logic [1:0]  i_req_mode,     // [1:0] mode
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [7:0]  i_rsp_data,     // [7:0] read_data
    output int          o_pending,
    output int          o_fail_count
);

    localparam logic [3:0] JOY_REMAP [16] = '{
        4'hf, 4'he, 4'hd, 4'h5, 4'hc, 4'h9, 4'h7, 4'h6,
        4'hb, 4'h3, 4'ha, 4'h4, 4'h1, 4'h2, 4'h0, 4'h8
    };

    logic [7:0] dip_b;
    logic [1:0] opm;
    logic [1:0] phase;
    logic [6:0] credits;
    logic [3:0] tally [2];
    logic [2:0] coins_needed [2];
    logic [2:0] credits_given [2];
    logic [2:0] load_left;
    logic       remap_on;
    logic [7:0] last_sw;
    logic [1:0] last_btn;

    logic [7:0] read_bytes_due [$];
    logic [7:0] due_byte;
    logic [7:0] next_byte;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic clear_chip();
        opm              = ccioc_pkg::OPM_SWITCH;
        phase            = ccioc_pkg::PHASE_FIRST;
        credits          = '0;
        tally[0]         = '0;
        tally[1]         = '0;
        coins_needed[0]  = '0;
        coins_needed[1]  = '0;
        credits_given[0] = '0;
        credits_given[1] = '0;
        load_left        = '0;
        remap_on         = 1'b0;
        last_sw          = '0;
        last_btn         = '0;
    endtask

    task automatic count_coin(input int slot);
        if (tally[slot] < ccioc_pkg::TALLY_MAX) begin
            tally[slot] = tally[slot] + 4'd1;
        end
        if (tally[slot] >= {1'b0, coins_needed[slot]}) begin
            credits     = credits + {4'b0000, credits_given[slot]};
            tally[slot] = tally[slot] - {1'b0, coins_needed[slot]};
        end
    endtask

    task automatic step_chip(input logic [1:0] mode, input logic [2:0] wd,
                             input logic [7:0] sw, output logic [7:0] rd);
        logic [1:0] ph;
        logic [7:0] act;
        logic [7:0] rise;
        logic [1:0] bitm;
        logic [1:0] level;
        logic       btn_rise;
        logic [3:0] joy;
        rd = '0;
        case (mode)
            ccioc_pkg::MODE_WRITE: begin
                if (load_left != 3'd0) begin
                    case (load_left)
                        3'd4: coins_needed[0] = wd;
                        3'd3: credits_given[0] = wd;
                        3'd2: coins_needed[1] = wd;
                        default: credits_given[1] = wd;
                    endcase
                    load_left = load_left - 3'd1;
                end else begin
                    case (wd)
                        ccioc_pkg::CMD_LOAD_COINAGE: begin
                            load_left = ccioc_pkg::LOAD_STEPS;
                            credits   = '0;
                        end
                        ccioc_pkg::CMD_CREDIT_MODE: begin
                            opm   = ccioc_pkg::OPM_CREDIT;
                            phase = ccioc_pkg::PHASE_FIRST;
                        end
                        ccioc_pkg::CMD_REMAP_OFF: remap_on = 1'b0;
                        ccioc_pkg::CMD_REMAP_ON: remap_on = 1'b1;
                        ccioc_pkg::CMD_SWITCH_MODE: begin
                            opm   = ccioc_pkg::OPM_SWITCH;
                            phase = ccioc_pkg::PHASE_FIRST;
                        end
                        default: ;
                    endcase
                end
            end
            ccioc_pkg::MODE_READ: begin
                ph    = phase;
                phase = (ph >= ccioc_pkg::PHASE_THIRD) ? ccioc_pkg::PHASE_FIRST : ph + 2'd1;
                if (opm == ccioc_pkg::OPM_SWITCH) begin
                    if (ph == ccioc_pkg::PHASE_FIRST) begin
                        rd = sw;
                    end else if (ph == ccioc_pkg::PHASE_SECOND) begin
                        rd = dip_b;
                    end
                end else if (ph == ccioc_pkg::PHASE_FIRST) begin
                    act     = ~sw;
                    rise    = act & ~last_sw;
                    last_sw = act;
                    if (coins_needed[0] != 3'd0) begin
                        if (credits < ccioc_pkg::CREDIT_CEILING) begin
                            if (rise[ccioc_pkg::SW_COIN1]) count_coin(0);
                            if (rise[ccioc_pkg::SW_COIN2]) count_coin(1);
                            if (rise[ccioc_pkg::SW_SERV]) credits = credits + 7'd1;
                        end
                    end else begin
                        credits = ccioc_pkg::FREE_PLAY_CRED;
                    end
                    if (opm == ccioc_pkg::OPM_CREDIT) begin
                        if (rise[ccioc_pkg::SW_START1]) begin
                            if (credits >= 7'd1) begin
                                credits = credits - 7'd1;
                                opm     = ccioc_pkg::OPM_STARTED;
                            end
                        end else if (rise[ccioc_pkg::SW_START2]) begin
                            if (credits >= 7'd2) begin
                                credits = credits - 7'd2;
                                opm     = ccioc_pkg::OPM_STARTED;
                            end
                        end
                    end
                    if (act[ccioc_pkg::SW_TEST]) begin
                        rd = ccioc_pkg::TEST_READ_BYTE;
                    end else begin
                        rd = {4'(credits / 7'd10), 4'(credits % 7'd10)};
                    end
                end else begin
                    bitm     = (ph == ccioc_pkg::PHASE_THIRD) ? 2'b10 : 2'b01;
                    level    = ~sw[1:0] & bitm;
                    btn_rise = |(level & ~last_btn);
                    last_btn = (last_btn & ~bitm) | level;
                    joy      = (ph == ccioc_pkg::PHASE_THIRD) ? dip_b[7:4] : dip_b[3:0];
                    if (remap_on) begin
                        joy = JOY_REMAP[joy];
                    end
                    rd = {2'b00, ~|level, ~btn_rise, joy};
                end
            end
            ccioc_pkg::MODE_CLEAR: clear_chip();
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_chip();
            dip_b = ccioc_pkg::DIP_B_RESET;
            read_bytes_due.delete();
            o_pending = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (read_bytes_due.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: unexpected read_data %02h", $time, i_rsp_data);
                    end
                    o_fail_count = o_fail_count + 1;
                end else begin
                    due_byte = read_bytes_due.pop_front();
                    if (i_rsp_data !== due_byte) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: read_data expected %02h, got %02h",
                                     $time, due_byte, i_rsp_data);
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                step_chip(i_req_mode, i_req_data[2:0], i_req_data[10:3], next_byte);
                read_bytes_due.push_back(next_byte);
            end
            if (i_cfg_wr_en) begin
                dip_b = i_cfg_wr_data;
            end
            o_pending = read_bytes_due.size();
        end
    end

endmodule

### bench/coin_credit_io_controller_unit_test.sv
`timescale 1ns / 1ps

module coin_credit_io_controller_unit_test;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0] CMD_IDLE0  = 3'd0;
    localparam logic [2:0] CMD_IDLE6  = 3'd6;
    localparam logic [2:0] CMD_IDLE7  = 3'd7;
    localparam int PHASE_REQUESTS = 320;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;   // [2:0] write_data, [10:3] switches, [15:11] zero
    logic [1:0]  s_axis_tuser = 2'b00;      // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;              // [7:0] read_data

    int pending;
    int fail_count;
    int send_burst = 0;
    int recv_burst = 0;
    int phase_sent = 0;

    coin_credit_io_controller_unit DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    coin_credit_io_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_mode    (s_axis_tuser),
        .i_rsp_valid   (m_axis_tvalid),
        .i_rsp_ready   (m_axis_tready),
        .i_rsp_data    (m_axis_tdata),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // drain results with random stalls
    initial begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (recv_burst > 0) begin
                stall      = 0;
                recv_burst = recv_burst - 1;
            end else begin
                stall = $urandom_range(0, 7);
                if ($urandom_range(0, 15) == 0) recv_burst = $urandom_range(8, 40);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_request(input logic [1:0] mode, input logic [2:0] wd,
                                input logic [7:0] sw);
        int gap;
        if (send_burst > 0) begin
            gap        = 0;
            send_burst = send_burst - 1;
        end else begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b00000, sw, wd};
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        phase_sent = phase_sent + 1;
    endtask

    task automatic settle_bus();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending != 0 && guard < 2000) begin
            @(negedge clk);
            guard = guard + 1;
        end
    endtask

    task automatic write_dip(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly idle test and start buttons, random coins
    function automatic logic [7:0] play_switches();
        logic [7:0] sw;
        sw                       = 8'($urandom_range(0, 255));
        sw[ccioc_pkg::SW_TEST]   = ($urandom_range(0, 15) != 0);
        sw[ccioc_pkg::SW_START1] = ($urandom_range(0, 5) != 0);
        sw[ccioc_pkg::SW_START2] = ($urandom_range(0, 5) != 0);
        return sw;
    endfunction

    task automatic play_session();
        int reads;
        if ($urandom_range(0, 7) == 0) begin
            send_request(ccioc_pkg::MODE_CLEAR, 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) != 0) begin
            send_request(ccioc_pkg::MODE_WRITE, ccioc_pkg::CMD_LOAD_COINAGE,
                         8'($urandom_range(0, 255)));
            repeat (4) begin
                send_request(ccioc_pkg::MODE_WRITE, 3'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)));
            end
        end
        send_request(ccioc_pkg::MODE_WRITE,
                     $urandom_range(0, 1) ? ccioc_pkg::CMD_REMAP_ON : ccioc_pkg::CMD_REMAP_OFF,
                     8'($urandom_range(0, 255)));
        send_request(ccioc_pkg::MODE_WRITE,
                     ($urandom_range(0, 4) != 0) ? ccioc_pkg::CMD_CREDIT_MODE
                                                 : ccioc_pkg::CMD_SWITCH_MODE,
                     8'($urandom_range(0, 255)));
        reads = $urandom_range(10, 80);
        repeat (reads) begin
            if ($urandom_range(0, 9) != 0) begin
                send_request(ccioc_pkg::MODE_READ, 3'($urandom_range(0, 7)), play_switches());
            end else begin
                send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(ccioc_pkg::MODE_READ, 3'd7, 8'h00);
        send_request(ccioc_pkg::MODE_READ, 3'd0, 8'hff);
        send_request(ccioc_pkg::MODE_READ, 3'd5, 8'h5a);
        send_request(MODE_SPARE, 3'd7, 8'hff);
        send_request(ccioc_pkg::MODE_WRITE, CMD_IDLE0, 8'h00);
        send_request(ccioc_pkg::MODE_WRITE, CMD_IDLE6, 8'hff);
        send_request(ccioc_pkg::MODE_WRITE, CMD_IDLE7, 8'h00);
        // no coin-2 divisor: each coin-2 press adds credits and the tally is never reduced
        send_request(ccioc_pkg::MODE_WRITE, ccioc_pkg::CMD_LOAD_COINAGE, 8'hff);
        send_request(ccioc_pkg::MODE_WRITE, 3'd2, 8'hff);
        send_request(ccioc_pkg::MODE_WRITE, 3'd1, 8'hff);
        send_request(ccioc_pkg::MODE_WRITE, 3'd0, 8'hff);
        send_request(ccioc_pkg::MODE_WRITE, 3'd7, 8'hff);
        send_request(ccioc_pkg::MODE_WRITE, ccioc_pkg::CMD_REMAP_ON, 8'hff);
        send_request(ccioc_pkg::MODE_WRITE, ccioc_pkg::CMD_CREDIT_MODE, 8'hff);
        send_request(ccioc_pkg::MODE_READ, 3'd0, 8'hff);
        send_request(ccioc_pkg::MODE_READ, 3'd0, 8'h00);
        send_request(ccioc_pkg::MODE_READ, 3'd0, 8'h00);
        send_request(ccioc_pkg::MODE_READ, 3'd0, 8'hff ^ (8'd1 << ccioc_pkg::SW_COIN2));
        send_request(ccioc_pkg::MODE_READ, 3'd0, 8'hff);
        send_request(ccioc_pkg::MODE_READ, 3'd0, 8'hff);
        send_request(ccioc_pkg::MODE_READ, 3'd0, 8'hff ^ (8'd1 << ccioc_pkg::SW_START1));
        send_request(ccioc_pkg::MODE_WRITE, ccioc_pkg::CMD_REMAP_OFF, 8'hff);
        send_request(ccioc_pkg::MODE_WRITE, ccioc_pkg::CMD_SWITCH_MODE, 8'hff);
        send_request(ccioc_pkg::MODE_CLEAR, 3'd0, 8'hff);
        send_request(ccioc_pkg::MODE_WRITE, ccioc_pkg::CMD_CREDIT_MODE, 8'hff);
        // free play with test switch on
        send_request(ccioc_pkg::MODE_READ, 3'd0, 8'hff ^ (8'd1 << ccioc_pkg::SW_TEST));
        settle_bus();

        for (int p = 0; p < 5; p++) begin
            if (p == 0) write_dip(8'hff);
            else if (p == 1) write_dip(8'h00);
            else write_dip(8'($urandom_range(0, 255)));
            phase_sent = 0;
            while (phase_sent < PHASE_REQUESTS) play_session();
            settle_bus();
        end

        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### coin_credit_io_controller_unit.f
design/ccioc_pkg.sv
design/coin_credit_io_controller_unit.sv
bench/coin_credit_io_checker.sv
bench/coin_credit_io_controller_unit_test.sv
